// File: rtl/cmh_pkg.sv
// shared widths, row codes, register indexes and coefficient tables
package cmh_pkg;

   localparam int SET_W    = 8;   // contrast, hue, saturation, gain, offset settings
   localparam int ANGLE_W  = 7;   // hue angle magnitude, 0..90 degrees
   localparam int TRIG_W   = 9;   // table sine and cosine, 0..256
   localparam int CHROMA_W = 9;   // saturation-scaled sine and cosine, 0..510
   localparam int LUMA_W   = 9;   // contrast times two
   localparam int PROD_W   = 10;  // one chroma product after the shift by 8
   localparam int MAG_W    = 11;  // combined chroma magnitude
   localparam int COEF_W   = 11;
   localparam int ROW_W    = 2;
   localparam int CSR_W    = 3;

   localparam logic [ANGLE_W-1:0] QUARTER_DEG = 7'd90;
   localparam logic [SET_W-1:0]   OFFSET_BASE = 8'h80;
   localparam logic [SET_W-1:0]   SET_UNITY   = 8'd128;

   localparam logic [ROW_W-1:0] ROW_RED   = 2'd0;
   localparam logic [ROW_W-1:0] ROW_GREEN = 2'd1;
   localparam logic [ROW_W-1:0] ROW_BLUE  = 2'd2;

   localparam logic [CSR_W-1:0] CSR_GAIN_RED     = 3'd0;
   localparam logic [CSR_W-1:0] CSR_GAIN_GREEN   = 3'd1;
   localparam logic [CSR_W-1:0] CSR_GAIN_BLUE    = 3'd2;
   localparam logic [CSR_W-1:0] CSR_OFFSET_RED   = 3'd3;
   localparam logic [CSR_W-1:0] CSR_OFFSET_GREEN = 3'd4;
   localparam logic [CSR_W-1:0] CSR_OFFSET_BLUE  = 3'd5;

   // one request after hue, saturation and contrast scaling
   typedef struct packed {
      logic                hue_neg;
      logic [CHROMA_W-1:0] sn;
      logic [CHROMA_W-1:0] cs;
      logic [LUMA_W-1:0]   luma_base;
   } cmh_item_type;

   // one matrix row on its way to the row datapath
   typedef struct packed {
      logic [ROW_W-1:0] row;
      cmh_item_type     item;
   } cmh_row_type;

   // Cb magnitude of each row in 1/256 units
   function automatic logic [TRIG_W-1:0] cb_mag(input logic [ROW_W-1:0] row);
      logic [TRIG_W-1:0] m;
      case (row)
         ROW_RED:   m = 9'h000;
         ROW_GREEN: m = 9'h058;
         ROW_BLUE:  m = 9'h1C5;
         default:   m = 9'h000;
      endcase
      return m;
   endfunction

   // Cr magnitude of each row in 1/256 units
   function automatic logic [TRIG_W-1:0] cr_mag(input logic [ROW_W-1:0] row);
      logic [TRIG_W-1:0] m;
      case (row)
         ROW_RED:   m = 9'h167;
         ROW_GREEN: m = 9'h0B6;
         ROW_BLUE:  m = 9'h000;
         default:   m = 9'h000;
      endcase
      return m;
   endfunction

   // sin(deg) * 256 for deg 0..90
   function automatic logic [TRIG_W-1:0] quarter_sine(input logic [ANGLE_W-1:0] deg);
      logic [TRIG_W-1:0] s;
      case (deg) inside
         7'd0:  s = 9'h000;  7'd1:  s = 9'h004;  7'd2:  s = 9'h008;  7'd3:  s = 9'h00D;
         7'd4:  s = 9'h011;  7'd5:  s = 9'h016;  7'd6:  s = 9'h01A;  7'd7:  s = 9'h01F;
         7'd8:  s = 9'h023;  7'd9:  s = 9'h028;  7'd10: s = 9'h02C;  7'd11: s = 9'h030;
         7'd12: s = 9'h035;  7'd13: s = 9'h039;  7'd14: s = 9'h03D;  7'd15: s = 9'h042;
         7'd16: s = 9'h046;  7'd17: s = 9'h04A;  7'd18: s = 9'h04F;  7'd19: s = 9'h053;
         7'd20: s = 9'h057;  7'd21: s = 9'h05B;  7'd22: s = 9'h05F;  7'd23: s = 9'h064;
         7'd24: s = 9'h068;  7'd25: s = 9'h06C;  7'd26: s = 9'h070;  7'd27: s = 9'h074;
         7'd28: s = 9'h078;  7'd29: s = 9'h07C;  7'd30: s = 9'h07F;  7'd31: s = 9'h083;
         7'd32: s = 9'h087;  7'd33: s = 9'h08B;  7'd34: s = 9'h08F;  7'd35: s = 9'h092;
         7'd36: s = 9'h096;  7'd37: s = 9'h09A;  7'd38: s = 9'h09D;  7'd39: s = 9'h0A1;
         7'd40: s = 9'h0A4;  7'd41: s = 9'h0A7;  7'd42: s = 9'h0AB;  7'd43: s = 9'h0AE;
         7'd44: s = 9'h0B1;  7'd45: s = 9'h0B5;  7'd46: s = 9'h0B8;  7'd47: s = 9'h0BB;
         7'd48: s = 9'h0BE;  7'd49: s = 9'h0C1;  7'd50: s = 9'h0C4;  7'd51: s = 9'h0C6;
         7'd52: s = 9'h0C9;  7'd53: s = 9'h0CC;  7'd54: s = 9'h0CF;  7'd55: s = 9'h0D1;
         7'd56: s = 9'h0D4;  7'd57: s = 9'h0D6;  7'd58: s = 9'h0D9;  7'd59: s = 9'h0DB;
         7'd60: s = 9'h0DD;  7'd61: s = 9'h0DF;  7'd62: s = 9'h0E2;  7'd63: s = 9'h0E4;
         7'd64: s = 9'h0E6;  7'd65: s = 9'h0E8;  7'd66: s = 9'h0E9;  7'd67: s = 9'h0EB;
         7'd68: s = 9'h0ED;  7'd69: s = 9'h0EE;  7'd70: s = 9'h0F0;  7'd71: s = 9'h0F2;
         7'd72: s = 9'h0F3;  7'd73: s = 9'h0F4;  7'd74: s = 9'h0F6;  7'd75: s = 9'h0F7;
         7'd76: s = 9'h0F8;  7'd77: s = 9'h0F9;  7'd78: s = 9'h0FA;  7'd79: s = 9'h0FB;
         7'd80, 7'd81: s = 9'h0FC;
         7'd82: s = 9'h0FD;
         7'd83, 7'd84: s = 9'h0FE;
         [7'd85:7'd89]: s = 9'h0FF;
         7'd90: s = 9'h100;
         default: s = 9'h000;
      endcase
      return s;
   endfunction

endpackage

// File: rtl/color_matrix_hue_sat_coeff.sv
// top level: colour matrix coefficient generator with hue, saturation and contrast
//
// req_ takes one picture-setting item (contrast, hue code, saturation) per handshake.
// rsp_ returns three items per request, red, green then blue rows of the
// YCbCr-to-RGB matrix; tuser carries the row number and tlast marks the blue row.
// csr_ writes the channel gains (indexes 0..2) and offsets (3..5); writes to other
// indexes are dropped. Write only while no request is in flight.
// The red row passes the front end, the row sequencer and the row datapath before it
// is presented; green and blue follow it when the receiver is ready.
// Throughput: one row per cycle while the receiver is ready; the row sequencer takes
// a new request only when empty or as the blue row of the last one leaves. The front end
// and the row datapath are each three register stages and take a new entry every cycle unless held.
// Reset clears all pipeline valid bits and sets every gain and offset to 128.
// When rsp_tready is low the pipeline holds; stages fill behind the output
// register and req_tready drops once they are full. Nothing is lost or repeated.
module color_matrix_hue_sat_coeff (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // contrast, hue_code, saturation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // luma_coeff, cb_coeff, cr_coeff, channel_offset, zero pad
   output logic [1:0]  rsp_tuser,   // row
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic [2:0][cmh_pkg::SET_W-1:0] gain_ff, offset_ff;

   logic                           front_valid, front_ready;
   cmh_pkg::cmh_item_type          front_item;
   logic                           seq_valid, seq_ready;
   cmh_pkg::cmh_row_type           seq_row;

   logic [cmh_pkg::COEF_W-1:0]     luma_coeff, cb_coeff, cr_coeff;
   logic [cmh_pkg::SET_W-1:0]      channel_offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= {3{cmh_pkg::SET_UNITY}};
         offset_ff <= {3{cmh_pkg::SET_UNITY}};
      end else if (csr_we) begin
         unique case (csr_index)
            cmh_pkg::CSR_GAIN_RED:     gain_ff[0]   <= csr_wdata;
            cmh_pkg::CSR_GAIN_GREEN:   gain_ff[1]   <= csr_wdata;
            cmh_pkg::CSR_GAIN_BLUE:    gain_ff[2]   <= csr_wdata;
            cmh_pkg::CSR_OFFSET_RED:   offset_ff[0] <= csr_wdata;
            cmh_pkg::CSR_OFFSET_GREEN: offset_ff[1] <= csr_wdata;
            cmh_pkg::CSR_OFFSET_BLUE:  offset_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   cmh_hue_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .contrast   (req_tdata[7:0]),
      .hue_code   (req_tdata[15:8]),
      .saturation (req_tdata[23:16]),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_item   (front_item)
   );

   cmh_row_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (seq_valid),
      .out_ready (seq_ready),
      .out_row   (seq_row)
   );

   cmh_row_calc u_calc (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (seq_valid),
      .in_ready       (seq_ready),
      .in_row         (seq_row),
      .gain           (gain_ff),
      .offset         (offset_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_row        (rsp_tuser),
      .luma_coeff     (luma_coeff),
      .cb_coeff       (cb_coeff),
      .cr_coeff       (cr_coeff),
      .channel_offset (channel_offset),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {7'd0, channel_offset, cr_coeff, cb_coeff, luma_coeff};

endmodule

// File: rtl/cmh_hue_front.sv
// per-request front end: hue angle, sine and cosine lookup, saturation scaling
module cmh_hue_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [cmh_pkg::SET_W-1:0]     contrast,
   input  logic [cmh_pkg::SET_W-1:0]     hue_code,
   input  logic [cmh_pkg::SET_W-1:0]     saturation,
   output logic                          out_valid,
   input  logic                          out_ready,
   output cmh_pkg::cmh_item_type         out_item
);

   logic                             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                             s1_ready, s2_ready, s3_ready;

   logic                             s1_hue_neg_ff;
   logic [cmh_pkg::ANGLE_W-1:0]      s1_mag_ff;
   logic [cmh_pkg::SET_W-1:0]        s1_sat_ff, s1_con_ff;

   logic                             s2_hue_neg_ff;
   logic [cmh_pkg::TRIG_W-1:0]       s2_sine_ff, s2_cosine_ff;
   logic [cmh_pkg::SET_W-1:0]        s2_sat_ff, s2_con_ff;

   cmh_pkg::cmh_item_type            s3_item_ff, s3_item_in;

   logic [14:0]                      hue_prod;
   logic [7:0]                       angle_ofs;
   logic                             hue_neg_in;
   logic [7:0]                       mag_wide;
   logic [cmh_pkg::ANGLE_W-1:0]      cos_deg;
   logic [16:0]                      sn_prod, cs_prod;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // angle + 90 = floor(hue * 90 / 128), 0..179
   always_comb begin
      hue_prod   = {7'd0, hue_code} * 15'd90;
      angle_ofs  = hue_prod[14:7];
      hue_neg_in = angle_ofs < 8'd90;
      mag_wide   = hue_neg_in ? (8'd90 - angle_ofs) : (angle_ofs - 8'd90);
   end

   assign cos_deg = cmh_pkg::QUARTER_DEG - s1_mag_ff;

   always_comb begin
      sn_prod = {8'd0, s2_sine_ff} * {9'd0, s2_sat_ff};
      cs_prod = {8'd0, s2_cosine_ff} * {9'd0, s2_sat_ff};
      s3_item_in.hue_neg   = s2_hue_neg_ff;
      s3_item_in.sn        = sn_prod[15:7];
      s3_item_in.cs        = cs_prod[15:7];
      s3_item_in.luma_base = {s2_con_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_hue_neg_ff <= hue_neg_in;
         s1_mag_ff     <= mag_wide[cmh_pkg::ANGLE_W-1:0];
         s1_sat_ff     <= saturation;
         s1_con_ff     <= contrast;
      end
      if (s2_ready) begin
         s2_hue_neg_ff <= s1_hue_neg_ff;
         s2_sine_ff    <= cmh_pkg::quarter_sine(s1_mag_ff);
         s2_cosine_ff  <= cmh_pkg::quarter_sine(cos_deg);
         s2_sat_ff     <= s1_sat_ff;
         s2_con_ff     <= s1_con_ff;
      end
      if (s3_ready) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// File: rtl/cmh_row_seq.sv
// row sequencer: holds one request and issues its red, green and blue rows
module cmh_row_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cmh_pkg::cmh_item_type  in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cmh_pkg::cmh_row_type   out_row
);

   logic                          valid_ff;
   logic [cmh_pkg::ROW_W-1:0]     row_ff;
   cmh_pkg::cmh_item_type         item_ff;
   logic                          load;

   // take the next item when empty or while the blue row leaves
   assign in_ready = !valid_ff || (out_ready && row_ff == cmh_pkg::ROW_BLUE);
   assign load     = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= cmh_pkg::ROW_RED;
      end else if (load) begin
         valid_ff <= in_valid;
         row_ff   <= cmh_pkg::ROW_RED;
      end else if (out_ready) begin
         row_ff   <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) item_ff <= in_item;
   end

   assign out_valid    = valid_ff;
   assign out_row.row  = row_ff;
   assign out_row.item = item_ff;

endmodule

// File: rtl/cmh_row_calc.sv
// row datapath: chroma products, rotation sign handling, gain and final coefficients
module cmh_row_calc (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  cmh_pkg::cmh_row_type                      in_row,
   input  logic [2:0][cmh_pkg::SET_W-1:0]            gain,
   input  logic [2:0][cmh_pkg::SET_W-1:0]            offset,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [cmh_pkg::ROW_W-1:0]                 out_row,
   output logic [cmh_pkg::COEF_W-1:0]                luma_coeff,
   output logic [cmh_pkg::COEF_W-1:0]                cb_coeff,
   output logic [cmh_pkg::COEF_W-1:0]                cr_coeff,
   output logic [cmh_pkg::SET_W-1:0]                 channel_offset,
   output logic                                      out_last
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   // stage 1: products
   logic [cmh_pkg::ROW_W-1:0]   s1_row_ff;
   logic [cmh_pkg::SET_W-1:0]   s1_gain_ff, s1_off_ff;
   logic                        s1_hue_neg_ff;
   logic [cmh_pkg::PROD_W-1:0]  s1_au_ff, s1_bu_ff, s1_av_ff, s1_bv_ff, s1_luma_ff;

   // stage 2: signed magnitudes
   logic [cmh_pkg::ROW_W-1:0]   s2_row_ff;
   logic [cmh_pkg::SET_W-1:0]   s2_gain_ff, s2_off_ff;
   logic [cmh_pkg::PROD_W-1:0]  s2_luma_ff;
   logic [cmh_pkg::MAG_W-1:0]   s2_mu_ff, s2_mv_ff, s2_mu_in, s2_mv_in;
   logic                        s2_negu_ff, s2_negv_ff, s2_negu_in, s2_negv_in;

   // stage 3: output register
   logic [cmh_pkg::ROW_W-1:0]   s3_row_ff;
   logic [cmh_pkg::COEF_W-1:0]  s3_luma_ff, s3_cb_ff, s3_cr_ff, s3_cb_in, s3_cr_in;
   logic [cmh_pkg::SET_W-1:0]   s3_off_ff;

   logic [cmh_pkg::SET_W-1:0]   gain_sel, offset_sel;
   logic [cmh_pkg::TRIG_W-1:0]  cbm, crm;
   logic [17:0]                 au_prod, bu_prod, av_prod, bv_prod;
   logic [16:0]                 luma_prod;
   logic [cmh_pkg::MAG_W-1:0]   au, bu, av, bv;
   logic [18:0]                 wu_prod, wv_prod;
   logic [cmh_pkg::COEF_W-1:0]  wu, wv;
   logic                        green, negu_row, negv_row;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      case (in_row.row)
         cmh_pkg::ROW_RED: begin
            gain_sel   = gain[0];
            offset_sel = offset[0];
         end
         cmh_pkg::ROW_GREEN: begin
            gain_sel   = gain[1];
            offset_sel = offset[1];
         end
         default: begin
            gain_sel   = gain[2];
            offset_sel = offset[2];
         end
      endcase
      cbm       = cmh_pkg::cb_mag(in_row.row);
      crm       = cmh_pkg::cr_mag(in_row.row);
      au_prod   = {9'd0, cbm} * {9'd0, in_row.item.cs};
      bu_prod   = {9'd0, crm} * {9'd0, in_row.item.sn};
      av_prod   = {9'd0, cbm} * {9'd0, in_row.item.sn};
      bv_prod   = {9'd0, crm} * {9'd0, in_row.item.cs};
      luma_prod = {8'd0, in_row.item.luma_base} * {9'd0, gain_sel};
   end

   // U = Mcb*cos + Mcr*sin, V = Mcr*cos - Mcb*sin, with the angle sign folded in
   always_comb begin
      au = {1'b0, s1_au_ff};
      bu = {1'b0, s1_bu_ff};
      av = {1'b0, s1_av_ff};
      bv = {1'b0, s1_bv_ff};
      if (s1_hue_neg_ff) begin
         if (au > bu) begin
            s2_mu_in   = au - bu;
            s2_negu_in = 1'b0;
         end else begin
            s2_mu_in   = bu - au;
            s2_negu_in = bu != '0;
         end
         s2_mv_in   = av + bv;
         s2_negv_in = 1'b0;
      end else begin
         s2_mu_in   = au + bu;
         s2_negu_in = 1'b0;
         if (av < bv) begin
            s2_mv_in   = bv - av;
            s2_negv_in = 1'b0;
         end else begin
            s2_mv_in   = av - bv;
            s2_negv_in = av != '0;
         end
      end
   end

   // gain, then the green row has its sign flag inverted
   always_comb begin
      wu_prod  = {8'd0, s2_mu_ff} * {11'd0, s2_gain_ff};
      wv_prod  = {8'd0, s2_mv_ff} * {11'd0, s2_gain_ff};
      wu       = wu_prod[17:7];
      wv       = wv_prod[17:7];
      green    = s2_row_ff == cmh_pkg::ROW_GREEN;
      negu_row = s2_negu_ff ^ green;
      negv_row = s2_negv_ff ^ green;
      s3_cb_in = negu_row ? (11'd0 - wu) : wu;
      s3_cr_in = negv_row ? (11'd0 - wv) : wv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_row_ff     <= in_row.row;
         s1_gain_ff    <= gain_sel;
         s1_off_ff     <= offset_sel + cmh_pkg::OFFSET_BASE;
         s1_hue_neg_ff <= in_row.item.hue_neg;
         s1_au_ff      <= au_prod[17:8];
         s1_bu_ff      <= bu_prod[17:8];
         s1_av_ff      <= av_prod[17:8];
         s1_bv_ff      <= bv_prod[17:8];
         s1_luma_ff    <= luma_prod[16:7];
      end
      if (s2_ready) begin
         s2_row_ff  <= s1_row_ff;
         s2_gain_ff <= s1_gain_ff;
         s2_off_ff  <= s1_off_ff;
         s2_luma_ff <= s1_luma_ff;
         s2_mu_ff   <= s2_mu_in;
         s2_mv_ff   <= s2_mv_in;
         s2_negu_ff <= s2_negu_in;
         s2_negv_ff <= s2_negv_in;
      end
      if (s3_ready) begin
         s3_row_ff  <= s2_row_ff;
         s3_luma_ff <= {1'b0, s2_luma_ff};
         s3_cb_ff   <= s3_cb_in;
         s3_cr_ff   <= s3_cr_in;
         s3_off_ff  <= s2_off_ff;
      end
   end

   assign out_valid      = s3_valid_ff;
   assign out_row        = s3_row_ff;
   assign luma_coeff     = s3_luma_ff;
   assign cb_coeff       = s3_cb_ff;
   assign cr_coeff       = s3_cr_ff;
   assign channel_offset = s3_off_ff;
   assign out_last       = s3_row_ff == cmh_pkg::ROW_BLUE;

endmodule
